### hdl/lsrp_pkg.sv
// ----------------------------------------------------------------------------
// lsrp_pkg
// Shared types, codes and helpers of the leap-and-shift rank proposal block.
// ----------------------------------------------------------------------------
package lsrp_pkg;

  localparam int MAX_ITEMS_DEF = 64;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_PROPOSE = 2'd1;
  localparam logic [1:0] OP_COMMIT  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADPICK = 2'd1;
  localparam logic [1:0] ST_NOPEND  = 2'd2;

  localparam logic REG_ITEM_COUNT = 1'b0;
  localparam logic REG_LEAP_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    K_LOAD,
    K_PROP,
    K_COMMIT
  } kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] item;
    logic [6:0] rank_value;
    logic [6:0] pick;
  } in_t;

  typedef struct packed {
    logic [5:0] out_item;
    logic [6:0] new_rank;
    logic       last;
    logic [6:0] support_forward;
    logic [6:0] support_backward;
    logic       adjacent;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] item;
    logic [6:0] rank_value;
    logic [6:0] pick;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

### hdl/lsrp_front.sv
// ----------------------------------------------------------------------------
// lsrp_front
// Accepts requests, classifies them and queues them for the execution unit.
// ----------------------------------------------------------------------------
module lsrp_front import lsrp_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  in_t   in_cmd,
  input  logic  pop,
  output head_t head
);

  localparam logic [6:0] MaxRank = 7'(MAX_ITEMS);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       keep;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.item       = in_cmd.item;
    cls.rank_value = in_cmd.rank_value;
    cls.pick       = in_cmd.pick;
    cls.kind       = K_LOAD;
    keep           = 1'b0;
    unique case (in_cmd.op)
      OP_LOAD: begin
        cls.kind = K_LOAD;
        keep = ({1'b0, in_cmd.item} < MaxRank) && (in_cmd.rank_value != 7'd0) &&
               (in_cmd.rank_value <= MaxRank);
      end
      OP_PROPOSE: begin
        cls.kind = K_PROP;
        keep = 1'b1;
      end
      OP_COMMIT: begin
        cls.kind = K_COMMIT;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy && keep;
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/lsrp_back.sv
// ----------------------------------------------------------------------------
// lsrp_back
// Executes queued requests against the rank tables and emits the results.
// ----------------------------------------------------------------------------
module lsrp_back import lsrp_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  head_t      head,
  output logic       pop,
  input  logic [6:0] item_count,
  input  logic [5:0] leap_span,
  output logic       out_valid,
  output out_t       out_res
);

  localparam int         AW      = $clog2(MAX_ITEMS);
  localparam logic [6:0] MaxRank = 7'(MAX_ITEMS);

  typedef enum logic [2:0] {S_IDLE, S_PRD, S_PSB, S_SHIFT, S_CLOOP, S_CFIN} state_t;

  logic [6:0] roi [MAX_ITEMS];
  logic [5:0] iar [MAX_ITEMS];
  logic [6:0] roi_q;
  logic [5:0] iar_q;

  state_t     st_r;
  cmd_t       cmd_r;
  logic [6:0] r_r, nr_r, sf_r, sb_r, pos_r;
  logic       up_r, adj_r;
  logic [5:0] pend_item_r;
  logic [6:0] pend_old_r, pend_new_r;
  logic       pend_v_r;
  out_t       out_r;
  logic       out_v_r;

  logic [6:0] n_eff, lw;
  logic [6:0] lowc, sf, nr, sb, moved, rd_pos, st_pos;
  logic       r_ok, up_c, up_p;
  logic [AW-1:0] roi_ra, iar_ra, roi_wa, iar_wa;
  logic [6:0] roi_wd;
  logic [5:0] iar_wd;
  logic       roi_we, iar_we;

  assign n_eff = (item_count > MaxRank) ? MaxRank : item_count;
  assign lw    = {1'b0, leap_span};
  assign pop   = (st_r == S_IDLE) && head.valid;

  always_comb begin
    r_ok = (roi_q != 7'd0) && (roi_q <= n_eff);
    lowc = min7(roi_q - 7'd1, lw);
    sf   = lowc + min7(n_eff - roi_q, lw);
    nr   = (cmd_r.pick < lowc) ? roi_q - lowc + cmd_r.pick
                               : roi_q + 7'd1 + cmd_r.pick - lowc;
    sb   = min7(nr_r - 7'd1, lw) + min7(n_eff - nr_r, lw);
    up_c = nr_r > r_r;
    up_p = pend_new_r > pend_old_r;
    moved = up_r ? pos_r - 7'd1 : pos_r + 7'd1;
    st_pos = up_r ? pos_r + 7'd1 : pos_r - 7'd1;
    priority case (st_r)
      S_IDLE:  rd_pos = up_p ? pend_old_r + 7'd1 : pend_old_r - 7'd1;
      S_PSB:   rd_pos = up_c ? r_r + 7'd1 : r_r - 7'd1;
      default: rd_pos = st_pos;
    endcase
  end

  always_comb begin
    roi_ra = head.cmd.item[AW-1:0];
    iar_ra = AW'(rd_pos - 7'd1);
    roi_we = 1'b0;
    iar_we = 1'b0;
    roi_wa = head.cmd.item[AW-1:0];
    iar_wa = AW'(head.cmd.rank_value - 7'd1);
    roi_wd = head.cmd.rank_value;
    iar_wd = head.cmd.item;
    priority case (st_r)
      S_IDLE: begin
        roi_we = pop && (head.cmd.kind == K_LOAD);
        iar_we = roi_we;
      end
      S_CLOOP: begin
        roi_we = 1'b1;
        iar_we = 1'b1;
        roi_wa = iar_q[AW-1:0];
        iar_wa = AW'(moved - 7'd1);
        roi_wd = moved;
        iar_wd = iar_q;
      end
      S_CFIN: begin
        roi_we = 1'b1;
        iar_we = 1'b1;
        roi_wa = pend_item_r[AW-1:0];
        iar_wa = AW'(pend_new_r - 7'd1);
        roi_wd = pend_new_r;
        iar_wd = pend_item_r;
      end
      default: begin
        roi_we = 1'b0;
        iar_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (roi_we) begin
      roi[roi_wa] <= roi_wd;
    end
    if (iar_we) begin
      iar[iar_wa] <= iar_wd;
    end
    roi_q <= roi[roi_ra];
    iar_q <= iar[iar_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pend_v_r    <= 1'b0;
      pend_item_r <= 6'd0;
      pend_old_r  <= 7'd1;
      pend_new_r  <= 7'd1;
      out_v_r     <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r <= head.cmd;
            unique case (head.cmd.kind)
              K_LOAD: pend_v_r <= 1'b0;
              K_PROP: begin
                if ({1'b0, head.cmd.item} >= n_eff) begin
                  pend_v_r <= 1'b0;
                  out_v_r  <= 1'b1;
                  out_r    <= '{head.cmd.item, 7'd0, 1'b1, 7'd0, 7'd0, 1'b0, ST_BADPICK};
                end else begin
                  st_r <= S_PRD;
                end
              end
              K_COMMIT: begin
                if (!pend_v_r) begin
                  out_v_r <= 1'b1;
                  out_r   <= '{6'd0, 7'd0, 1'b1, 7'd0, 7'd0, 1'b0, ST_NOPEND};
                end else begin
                  up_r  <= up_p;
                  pos_r <= rd_pos;
                  st_r  <= S_CLOOP;
                end
              end
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_PRD: begin
          r_r  <= roi_q;
          nr_r <= nr;
          sf_r <= sf;
          if (!r_ok) begin
            pend_v_r <= 1'b0;
            out_v_r  <= 1'b1;
            out_r    <= '{cmd_r.item, roi_q, 1'b1, 7'd0, 7'd0, 1'b0, ST_BADPICK};
            st_r     <= S_IDLE;
          end else if (cmd_r.pick >= sf) begin
            pend_v_r <= 1'b0;
            out_v_r  <= 1'b1;
            out_r    <= '{cmd_r.item, roi_q, 1'b1, sf, 7'd0, 1'b0, ST_BADPICK};
            st_r     <= S_IDLE;
          end else begin
            st_r <= S_PSB;
          end
        end
        S_PSB: begin
          sb_r        <= sb;
          up_r        <= up_c;
          adj_r       <= (rd_pos == nr_r);
          pos_r       <= rd_pos;
          pend_item_r <= cmd_r.item;
          pend_old_r  <= r_r;
          pend_new_r  <= nr_r;
          pend_v_r    <= 1'b1;
          out_v_r     <= 1'b1;
          out_r       <= '{cmd_r.item, nr_r, (nr_r == r_r), sf_r, sb,
                           (rd_pos == nr_r), ST_OK};
          st_r        <= S_SHIFT;
        end
        S_SHIFT: begin
          out_v_r <= 1'b1;
          out_r   <= '{iar_q, moved, (pos_r == nr_r), sf_r, sb_r, adj_r, ST_OK};
          if (pos_r == nr_r) begin
            st_r <= S_IDLE;
          end else begin
            pos_r <= st_pos;
          end
        end
        S_CLOOP: begin
          if (pos_r == pend_new_r) begin
            st_r <= S_CFIN;
          end else begin
            pos_r <= st_pos;
          end
        end
        S_CFIN: begin
          pend_v_r <= 1'b0;
          out_v_r  <= 1'b1;
          out_r    <= '{pend_item_r, pend_new_r, 1'b1, 7'd0, 7'd0, 1'b0, ST_OK};
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_nopend: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.status == ST_NOPEND) |-> !pend_v_r)
    else $error("empty-commit result while a proposal is pending");
  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SHIFT) |-> (pos_r != r_r))
    else $error("shift walk reached the old rank");
  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_v_r) |-> ($past(st_r) == S_PSB))
    else $error("proposal recorded outside the support stage");
`endif

endmodule

### hdl/leap_and_shift_rank_proposal.sv
// ----------------------------------------------------------------------------
// leap_and_shift_rank_proposal
// A load is written to the rank tables when the back end pops it. A proposal
// reads the old rank in S_PRD, registers its first result in S_PSB and then one
// result per cycle in S_SHIFT, |new-old|+1 in all; a commit moves the shifted
// entries in S_CLOOP and answers from S_CFIN; a rejected request is answered
// from idle or S_PRD. The back end pops only when idle; busy is high while the
// two-request queue is full. Results are not stallable. Synchronous active-low
// reset clears the queue, pending proposal and control registers, not the tables.
// ----------------------------------------------------------------------------
module leap_and_shift_rank_proposal import lsrp_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_cmd,
  output logic       out_valid,
  output out_t       out_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0] item_count_r;
  logic [5:0] leap_span_r;
  head_t      head;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= 7'd64;
      leap_span_r  <= 6'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ITEM_COUNT: item_count_r <= cfg_data;
        REG_LEAP_SIZE:  leap_span_r  <= cfg_data[5:0];
        default:        item_count_r <= item_count_r;
      endcase
    end
  end

  lsrp_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_cmd (in_cmd),
    .pop    (pop),
    .head   (head)
  );

  lsrp_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .item_count (item_count_r),
    .leap_span  (leap_span_r),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

endmodule

### verif/tb_leap_and_shift_rank_proposal.sv
// ----------------------------------------------------------------------------
// tb_leap_and_shift_rank_proposal
// Self-checking testbench for the leap-and-shift rank proposal block. It loads
// a full permutation, then runs directed and random loads, proposals and
// commits under several item count and leap size settings. A rank table
// predictor computes the expected results, which are compared field by field
// with every result strobe.
// ----------------------------------------------------------------------------
import lsrp_pkg::*;

class rank_scoreboard;
  logic [6:0] rank_of[64];
  logic [5:0] item_at[64];
  logic [5:0] pend_item;
  logic [6:0] pend_old;
  logic [6:0] pend_new;
  bit         pend_valid;
  int         item_count;
  int         leap_span;
  out_t       expected_q[$];
  int         mismatches;

  function new();
    pend_item = 0;
    pend_old = 1;
    pend_new = 1;
    pend_valid = 0;
    item_count = 64;
    leap_span = 1;
    mismatches = 0;
  endfunction

  function int reach(int r, int n, int l);
    int lo;
    int hi;
    lo = (r - 1 < l) ? r - 1 : l;
    hi = (n - r < l) ? n - r : l;
    if (lo < 0) lo = 0;
    if (hi < 0) hi = 0;
    return lo + hi;
  endfunction

  function void push_result(int it, int rk, bit lst, int sf, int sb, bit adj,
                            logic [1:0] st);
    out_t o;
    o.out_item = it[5:0];
    o.new_rank = rk[6:0];
    o.last = lst;
    o.support_forward = sf[6:0];
    o.support_backward = sb[6:0];
    o.adjacent = adj;
    o.status = st;
    expected_q.push_back(o);
  endfunction

  function void note_request(in_t c);
    int n;
    int l;
    int r;
    int sf;
    int lowc;
    int nr;
    int sb;
    int d;
    int ad;
    int pr;
    logic [5:0] it;
    n = (item_count > 64) ? 64 : item_count;
    l = leap_span;
    if (c.op == OP_LOAD) begin
      if (c.rank_value >= 1 && c.rank_value <= 64) begin
        rank_of[c.item] = c.rank_value;
        item_at[c.rank_value - 1] = c.item;
        pend_valid = 0;
      end
    end else if (c.op == OP_PROPOSE) begin
      if (c.item >= n) begin
        pend_valid = 0;
        push_result(c.item, 0, 1, 0, 0, 0, ST_BADPICK);
        return;
      end
      r = rank_of[c.item];
      if (r < 1 || r > n) begin
        pend_valid = 0;
        push_result(c.item, r, 1, 0, 0, 0, ST_BADPICK);
        return;
      end
      sf = reach(r, n, l);
      if (c.pick >= sf) begin
        pend_valid = 0;
        push_result(c.item, r, 1, sf, 0, 0, ST_BADPICK);
        return;
      end
      lowc = (r - 1 < l) ? r - 1 : l;
      if (c.pick < lowc) nr = r - lowc + c.pick;
      else nr = r + 1 + c.pick - lowc;
      sb = reach(nr, n, l);
      d = nr - r;
      ad = (d < 0) ? -d : d;
      push_result(c.item, nr, ad == 0, sf, sb, ad == 1, ST_OK);
      for (int k = 1; k <= ad; k++) begin
        pr = (d > 0) ? r + k : r - k;
        push_result(item_at[pr - 1], (d > 0) ? pr - 1 : pr + 1, k == ad, sf, sb,
                    ad == 1, ST_OK);
      end
      pend_item = c.item;
      pend_old = r[6:0];
      pend_new = nr[6:0];
      pend_valid = 1;
    end else if (c.op == OP_COMMIT) begin
      if (!pend_valid) begin
        push_result(0, 0, 1, 0, 0, 0, ST_NOPEND);
        return;
      end
      r = pend_old;
      nr = pend_new;
      if (nr > r) begin
        for (int k = r + 1; k <= nr; k++) begin
          it = item_at[k - 1];
          rank_of[it] = 7'(k - 1);
          item_at[k - 2] = it;
        end
      end else begin
        for (int k = r - 1; k >= nr; k--) begin
          it = item_at[k - 1];
          rank_of[it] = 7'(k + 1);
          item_at[k] = it;
        end
      end
      item_at[nr - 1] = pend_item;
      rank_of[pend_item] = nr[6:0];
      pend_valid = 0;
      push_result(pend_item, nr, 1, 0, 0, 0, ST_OK);
    end
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result %p", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_item !== want.out_item || got.new_rank !== want.new_rank ||
        got.last !== want.last || got.support_forward !== want.support_forward ||
        got.support_backward !== want.support_backward ||
        got.adjacent !== want.adjacent || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
    end
  endfunction
endclass

module tb_leap_and_shift_rank_proposal;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_t in_cmd = '0;
  logic out_valid;
  out_t out_res;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [6:0] cfg_data = 0;

  rank_scoreboard sb = new();
  bit no_gaps;

  leap_and_shift_rank_proposal DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  task automatic send(input logic [1:0] op, input int item, input int rv,
                      input int pick);
    in_t c;
    int gap;
    bit ok;
    c.op = op;
    c.item = item[5:0];
    c.rank_value = rv[6:0];
    c.pick = pick[6:0];
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_cmd <= c;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    sb.note_request(c);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    bit ok;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value[6:0];
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    if (idx == REG_ITEM_COUNT) sb.item_count = value & 7'h7f;
    else sb.leap_span = value & 6'h3f;
  endtask

  task automatic configure(input int n, input int l);
    drain();
    write_reg(REG_ITEM_COUNT, n);
    write_reg(REG_LEAP_SIZE, l);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(input int count);
    int a;
    int b;
    int ra;
    int rb;
    int n;
    n = sb.item_count;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      case ($urandom_range(0, 19))
        0: begin
          a = $urandom_range(0, 63);
          b = $urandom_range(0, 63);
          ra = sb.rank_of[a];
          rb = sb.rank_of[b];
          send(OP_LOAD, a, rb, 0);
          send(OP_LOAD, b, ra, 0);
        end
        1: send(OP_LOAD, $urandom_range(0, 63),
                $urandom_range(0, 1) ? 0 : $urandom_range(65, 127), $urandom);
        2: send(OP_UNUSED, $urandom, $urandom, $urandom);
        3: send(OP_COMMIT, $urandom, $urandom, $urandom);
        4: send(OP_PROPOSE, $urandom_range(0, 63), $urandom, $urandom_range(0, 127));
        default: begin
          send(OP_PROPOSE, $urandom_range(0, n - 1), $urandom,
               $urandom_range(0, 2 * sb.leap_span - 1));
          if ($urandom_range(0, 9) < 7) send(OP_COMMIT, $urandom, $urandom, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    int perm[64];
    int t;
    int j;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    configure(64, 1);
    foreach (perm[i]) perm[i] = i;
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    no_gaps = 1;
    foreach (perm[i]) send(OP_LOAD, perm[i], i + 1, 0);
    no_gaps = 0;

    send(OP_COMMIT, 63, 127, 127);
    send(OP_LOAD, 63, 0, 0);
    send(OP_LOAD, 0, 127, 127);
    send(OP_UNUSED, 63, 127, 127);
    send(OP_PROPOSE, sb.item_at[0], 0, 0);
    send(OP_COMMIT, 0, 0, 0);
    send(OP_PROPOSE, sb.item_at[63], 0, 0);
    send(OP_COMMIT, 0, 0, 0);
    send(OP_PROPOSE, sb.item_at[63], 0, 1);
    send(OP_PROPOSE, 5, 0, 127);
    configure(64, 63);
    send(OP_PROPOSE, sb.item_at[0], 0, 62);
    send(OP_COMMIT, 0, 0, 0);
    send(OP_PROPOSE, sb.item_at[63], 0, 0);
    send(OP_LOAD, 7, 64, 0);
    send(OP_COMMIT, 0, 0, 0);
    configure(2, 1);
    send(OP_PROPOSE, 63, 0, 0);
    send(OP_PROPOSE, sb.item_at[0], 0, 0);
    send(OP_COMMIT, 0, 0, 0);

    configure(64, 1);
    random_phase(20);
    configure(64, 63);
    random_phase(20);
    configure(10, 5);
    random_phase(20);
    drain();
    configure(2, 1);
    random_phase(15);
    configure(33, 20);
    random_phase(20);
    configure(64, 17);
    random_phase(20);
    configure(5, 63);
    random_phase(15);
    configure(127, 3);
    random_phase(15);
    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[leap_and_shift_rank_proposal] OK");
    end else begin
      $display("[leap_and_shift_rank_proposal] ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 1_500_000);
    $display("[leap_and_shift_rank_proposal] ERROR");
    $finish;
  end
endmodule
